// ----- design/icds_pkg.sv -----
// Package for the IR-cut day/night switch: shared types, register indexes,
// reset values and the phase and command codes.
// No dependencies.
package icds_pkg;

   // Field widths
   localparam int SAMPLE_W = 12;
   localparam int PULSE_W  = 10;
   localparam int COUNT_W  = 16;
   localparam int PHASE_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_MS        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CONFIRM_MS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_MS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF_MS      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_START_DELAY_MS  = 3'd5;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] RST_LIGHT_THRESHOLD = 12'd512;
   localparam logic [PULSE_W-1:0]  RST_PULSE_MS        = 10'd50;
   localparam logic [PULSE_W-1:0]  RST_CONFIRM_MS      = 10'd100;
   localparam logic [COUNT_W-1:0]  RST_PERIOD_MS       = 16'd1000;
   localparam logic [COUNT_W-1:0]  RST_HOLDOFF_MS      = 16'd3000;
   localparam logic [COUNT_W-1:0]  RST_START_DELAY_MS  = 16'd2000;

   // Item commands
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_MANUAL = 1'b1;

   // Phase codes
   localparam logic [PHASE_W-1:0] PH_STARTUP = 2'd0;
   localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd1;
   localparam logic [PHASE_W-1:0] PH_CONFIRM = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [SAMPLE_W-1:0] light_threshold;
      logic [PULSE_W-1:0]  pulse_ms;
      logic [PULSE_W-1:0]  confirm_ms;
      logic [COUNT_W-1:0]  period_ms;
      logic [COUNT_W-1:0]  holdoff_ms;
      logic [COUNT_W-1:0]  start_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic pin_a;
      logic pin_b;
      logic filter_on;
      logic busy_res;
   } result_type;

endpackage

// ----- design/icds_csr.sv -----
// Configuration registers of the IR-cut day/night switch.
// Depends on icds_pkg.
module icds_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [icds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [icds_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output icds_pkg::cfg_type                 cfg
);

   icds_pkg::cfg_type cfg_ff;
   icds_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            icds_pkg::REG_LIGHT_THRESHOLD:
               cfg_in.light_threshold = csr_wdata[icds_pkg::SAMPLE_W-1:0];
            icds_pkg::REG_PULSE_MS:
               cfg_in.pulse_ms = csr_wdata[icds_pkg::PULSE_W-1:0];
            icds_pkg::REG_CONFIRM_MS:
               cfg_in.confirm_ms = csr_wdata[icds_pkg::PULSE_W-1:0];
            icds_pkg::REG_PERIOD_MS:
               cfg_in.period_ms = csr_wdata[icds_pkg::COUNT_W-1:0];
            icds_pkg::REG_HOLDOFF_MS:
               cfg_in.holdoff_ms = csr_wdata[icds_pkg::COUNT_W-1:0];
            icds_pkg::REG_START_DELAY_MS:
               cfg_in.start_delay_ms = csr_wdata[icds_pkg::COUNT_W-1:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_threshold <= icds_pkg::RST_LIGHT_THRESHOLD;
         cfg_ff.pulse_ms        <= icds_pkg::RST_PULSE_MS;
         cfg_ff.confirm_ms      <= icds_pkg::RST_CONFIRM_MS;
         cfg_ff.period_ms       <= icds_pkg::RST_PERIOD_MS;
         cfg_ff.holdoff_ms      <= icds_pkg::RST_HOLDOFF_MS;
         cfg_ff.start_delay_ms  <= icds_pkg::RST_START_DELAY_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/icds_ctrl.sv -----
// Switch state and its update for one item: phases, counters, motor pulse.
// Depends on icds_pkg.
module icds_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step_en,
   input  logic                            cmd,
   input  logic [icds_pkg::SAMPLE_W-1:0]   sample,
   input  logic                            manual_on,
   input  icds_pkg::cfg_type               cfg,
   output icds_pkg::result_type            result
);

   logic [icds_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [icds_pkg::COUNT_W-1:0] phase_count_ff, phase_count_in;
   logic [icds_pkg::COUNT_W-1:0] holdoff_ff, holdoff_in;
   logic                         first_bright_ff, first_bright_in;
   logic                         filter_ff, filter_in;
   logic [icds_pkg::PULSE_W-1:0] pulse_count_ff, pulse_count_in;
   logic                         pulse_dir_ff, pulse_dir_in;

   logic [icds_pkg::PULSE_W-1:0] pulse_len;
   logic [icds_pkg::COUNT_W-1:0] holdoff_inc;
   logic [icds_pkg::COUNT_W-1:0] idle_inc;
   logic [icds_pkg::COUNT_W-1:0] confirm_ext;
   logic                         bright;
   logic                         agree;
   logic                         want_on;
   logic                         active;

   assign pulse_len   = (cfg.pulse_ms == '0) ? icds_pkg::PULSE_W'(1) : cfg.pulse_ms;
   assign holdoff_inc = (holdoff_ff != icds_pkg::COUNT_MAX) ?
                        holdoff_ff + icds_pkg::COUNT_W'(1) : holdoff_ff;
   assign idle_inc    = phase_count_ff + icds_pkg::COUNT_W'(1);
   assign confirm_ext = {{(icds_pkg::COUNT_W-icds_pkg::PULSE_W){1'b0}}, cfg.confirm_ms};
   assign bright      = sample > cfg.light_threshold;
   assign agree       = first_bright_ff ? (sample != '0 && sample >= cfg.light_threshold)
                                        : !bright;
   assign want_on     = !first_bright_ff;

   always_comb begin
      phase_in        = phase_ff;
      phase_count_in  = phase_count_ff;
      holdoff_in      = holdoff_ff;
      first_bright_in = first_bright_ff;
      filter_in       = filter_ff;
      pulse_count_in  = pulse_count_ff;
      pulse_dir_in    = pulse_dir_ff;

      if (cmd == icds_pkg::CMD_MANUAL) begin
         // manual set, ignored while a pulse runs
         if (pulse_count_ff == '0) begin
            pulse_dir_in   = manual_on;
            filter_in      = manual_on;
            pulse_count_in = pulse_len;
         end
      end else begin
         holdoff_in = holdoff_inc;
         if (pulse_count_ff != '0) begin
            // pulse running: phases stand still
            pulse_count_in = pulse_count_ff - icds_pkg::PULSE_W'(1);
         end else begin
            unique case (phase_ff)
               icds_pkg::PH_STARTUP: begin
                  if (phase_count_ff >= cfg.start_delay_ms) begin
                     pulse_dir_in   = !bright;
                     filter_in      = !bright;
                     pulse_count_in = pulse_len;
                     holdoff_in     = '0;
                     phase_in       = icds_pkg::PH_IDLE;
                     phase_count_in = '0;
                  end else begin
                     phase_count_in = idle_inc;
                  end
               end
               icds_pkg::PH_CONFIRM: begin
                  if (phase_count_ff >= confirm_ext) begin
                     if (agree && filter_ff != want_on) begin
                        pulse_dir_in   = want_on;
                        filter_in      = want_on;
                        pulse_count_in = pulse_len;
                        holdoff_in     = '0;
                     end
                     phase_in       = icds_pkg::PH_IDLE;
                     phase_count_in = '0;
                  end else begin
                     phase_count_in = idle_inc;
                  end
               end
               default: begin
                  // idle: count the period, then take the first sample once the holdoff has run out
                  phase_in       = icds_pkg::PH_IDLE;
                  phase_count_in = idle_inc;
                  if (idle_inc >= cfg.period_ms) begin
                     phase_count_in = '0;
                     if (holdoff_inc >= cfg.holdoff_ms) begin
                        first_bright_in = bright;
                        phase_in        = icds_pkg::PH_CONFIRM;
                     end
                  end
               end
            endcase
         end
      end
   end

   assign active           = pulse_count_in != '0;
   assign result.pin_a     = active && pulse_dir_in;
   assign result.pin_b     = active && !pulse_dir_in;
   assign result.filter_on = filter_in;
   assign result.busy_res  = active;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= icds_pkg::PH_STARTUP;
         phase_count_ff  <= '0;
         holdoff_ff      <= '0;
         first_bright_ff <= 1'b0;
         filter_ff       <= 1'b0;
         pulse_count_ff  <= '0;
         pulse_dir_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         phase_count_ff  <= phase_count_in;
         holdoff_ff      <= holdoff_in;
         first_bright_ff <= first_bright_in;
         filter_ff       <= filter_in;
         pulse_count_ff  <= pulse_count_in;
         pulse_dir_ff    <= pulse_dir_in;
      end
   end

endmodule

// ----- design/ir_cut_day_night_switch_core.sv -----
// IR-cut day/night switch, top level. An accepted item is held in the input register;
// its result then goes to the result register. Throughput: one item per cycle while
// the result channel does not stall; the state update sits between the two registers,
// so back-to-back ticks and manual sets are taken every cycle unless rsp_stall holds
// the result register. Reset (synchronous, active high) clears both stages, puts the
// switch in startup wait and loads the register defaults. Depends on icds_pkg.
module ir_cut_day_night_switch_core (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [icds_pkg::SAMPLE_W-1:0]     req_adc_sample,
   input  logic                              req_manual_on,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_pin_a,
   output logic                              rsp_pin_b,
   output logic                              rsp_filter_on,
   output logic                              rsp_busy_res,
   // configuration write port
   input  logic                              csr_we,
   input  logic [icds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [icds_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   icds_pkg::cfg_type    cfg;
   icds_pkg::result_type step_result;

   // Input register stage
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_cmd_ff;
   logic [icds_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic                          s1_manual_ff;

   // Result register stage
   logic                          rsp_valid_ff, rsp_valid_in;
   icds_pkg::result_type          rsp_data_ff;

   logic req_fire;
   logic s1_advance;
   logic rsp_free;

   // The result register frees up when empty or when its item is taken
   // this cycle; the input stage advances into it whenever it is free.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && rsp_free;
   assign req_stall  = s1_valid_ff && !rsp_free;
   assign req_fire   = req_valid && !req_stall;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && rsp_stall);

   icds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // State advances exactly once per item, as the item leaves the input stage
   icds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .step_en   (s1_advance),
      .cmd       (s1_cmd_ff),
      .sample    (s1_sample_ff),
      .manual_on (s1_manual_ff),
      .cfg       (cfg),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff    <= req_cmd;
         s1_sample_ff <= req_adc_sample;
         s1_manual_ff <= req_manual_on;
      end
      if (s1_advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_a     = rsp_data_ff.pin_a;
   assign rsp_pin_b     = rsp_data_ff.pin_b;
   assign rsp_filter_on = rsp_data_ff.filter_on;
   assign rsp_busy_res  = rsp_data_ff.busy_res;

   // Never drive both motor pins
   a_pins_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.pin_a && rsp_data_ff.pin_b))
      else $error("both motor pins driven");

   // Busy exactly while one pin is driven
   a_busy_matches_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.busy_res == (rsp_data_ff.pin_a || rsp_data_ff.pin_b)))
      else $error("busy flag disagrees with motor pins");

   // A pulse always points the same way as the filter state it set
   a_pulse_dir_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.busy_res |-> (rsp_data_ff.pin_a == rsp_data_ff.filter_on))
      else $error("pulse direction disagrees with filter state");

   // An item blocked in the input stage stays there
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_cmd_ff)
                                     && $stable(s1_sample_ff))
      else $error("input stage lost a blocked item");

   // A result moves only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s1_advance |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

endmodule
